FILE: design/fxc_pkg.sv
// ---------------------------------------------------------------------------
// fxc_pkg: shared types and constants for the frame receiver
// Phase codes, result kinds and the result record passed between stages.
// ---------------------------------------------------------------------------
`default_nettype none

package fxc_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    localparam int KIND_W = 2;
    localparam int PH_W   = 3;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'hff;

    // parser phases; the two unused codes behave as hunting
    localparam logic [PH_W-1:0] PH_HUNT    = 3'd0;
    localparam logic [PH_W-1:0] PH_TYPE    = 3'd1;
    localparam logic [PH_W-1:0] PH_LEN_HI  = 3'd2;
    localparam logic [PH_W-1:0] PH_LEN_LO  = 3'd3;
    localparam logic [PH_W-1:0] PH_PAYLOAD = 3'd4;
    localparam logic [PH_W-1:0] PH_CHECK   = 3'd5;

    localparam logic [KIND_W-1:0] KIND_TYPE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END     = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0]  frame_length;
        logic              frame_ok;
        logic              last;
        logic [KIND_W-1:0] item_kind;
        logic [BYTE_W-1:0] out_byte;
    } fxc_result_t;

endpackage

`default_nettype wire

FILE: design/frame_receiver_xor_check.sv
// ---------------------------------------------------------------------------
// frame_receiver_xor_check: length-prefixed frame receiver, XOR checksum
// Hunts for 0xff, then reads type, 16-bit big-endian length, payload, check.
// ---------------------------------------------------------------------------
// Takes one byte per cycle with no gaps while the output is not stalled. A
// byte is held in the input register, then parsed into the result register
// that drives m_*. Each byte is handled in a single pass through the parser,
// whose frame state updates with every byte it takes. A byte that gives a
// word waits in the input register while the result register is full and
// m_tready is low, which also drops s_tready.
// Start and length bytes give no output word; the type byte, every payload
// byte and the checksum byte each give one. The checksum word has tlast set,
// carries the payload length and the pass/fail flag, and out_byte is zero.
// A frame is never cut short: a long frame waits for more bytes.
`default_nettype none

module frame_receiver_xor_check
    import fxc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] out_byte, [23:8] frame_length
    output logic [2:0]       m_tuser,   // [1:0] item_kind, [2] frame_ok
    output logic             m_tlast
);

    logic              item_valid;
    logic [BYTE_W-1:0] item_byte;
    logic              item_take;
    logic              res_valid;
    logic              res_ready;
    fxc_result_t       res;

    fxc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_take  (item_take)
    );

    fxc_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_take  (item_take),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready)
    );

    fxc_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

FILE: design/fxc_in_stage.sv
// ---------------------------------------------------------------------------
// fxc_in_stage: input register
// Holds one received byte; refills in the same cycle the parser takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module fxc_in_stage
    import fxc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] s_tdata,
    output logic                   item_valid,
    output logic [BYTE_W-1:0]      item_byte,
    input  wire logic              item_take
);

    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign s_tready = !valid_reg || item_take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule

`default_nettype wire

FILE: design/fxc_parser.sv
// ---------------------------------------------------------------------------
// fxc_parser: frame state machine and XOR checksum
// Consumes one byte per cycle unless a result is held back by res_ready; builds at most one result per byte.
// ---------------------------------------------------------------------------
`default_nettype none

module fxc_parser
    import fxc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              item_valid,
    input  wire logic [BYTE_W-1:0] item_byte,
    output logic                   item_take,
    output logic                   res_valid,
    output fxc_result_t            res,
    input  wire logic              res_ready
);

    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [LEN_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic              has_result;
    logic [LEN_W-1:0]  length_full;
    logic [LEN_W-1:0]  left_dec;

    assign length_full = {length_reg[LEN_W-1:BYTE_W], item_byte};
    assign left_dec    = bytes_left_reg - LEN_W'(1);

    always_comb begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        xor_next        = xor_reg;
        length_next     = length_reg;
        has_result      = 1'b0;
        res             = '0;
        case (phase_reg)
            PH_TYPE: begin
                xor_next       = xor_reg ^ item_byte;
                phase_next     = PH_LEN_HI;
                has_result     = 1'b1;
                res.out_byte   = item_byte;
                res.item_kind  = KIND_TYPE;
            end
            PH_LEN_HI: begin
                xor_next    = xor_reg ^ item_byte;
                length_next = {item_byte, BYTE_W'(0)};
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                xor_next        = xor_reg ^ item_byte;
                length_next     = length_full;
                bytes_left_next = length_full;
                phase_next      = (length_full == '0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                xor_next        = xor_reg ^ item_byte;
                bytes_left_next = left_dec;
                if (left_dec == '0) begin
                    phase_next = PH_CHECK;
                end
                has_result     = 1'b1;
                res.out_byte   = item_byte;
                res.item_kind  = KIND_PAYLOAD;
            end
            PH_CHECK: begin
                has_result       = 1'b1;
                res.item_kind    = KIND_END;
                res.frame_ok     = (item_byte == xor_reg);
                res.frame_length = length_reg;
                res.last         = 1'b1;
                phase_next       = PH_HUNT;
                bytes_left_next  = '0;
                xor_next         = '0;
            end
            default: begin
                // hunting; anything but the start byte is dropped
                if (item_byte == START_BYTE) begin
                    xor_next        = START_BYTE;
                    bytes_left_next = '0;
                    length_next     = '0;
                    phase_next      = PH_TYPE;
                end else begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    assign item_take = item_valid && (!has_result || res_ready);
    assign res_valid = item_valid && has_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT;
            bytes_left_reg <= '0;
            xor_reg        <= '0;
            length_reg     <= '0;
        end else if (item_take) begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            xor_reg        <= xor_next;
            length_reg     <= length_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/fxc_out_stage.sv
// ---------------------------------------------------------------------------
// fxc_out_stage: result register
// Holds one result word for the output channel and packs it onto the bus.
// ---------------------------------------------------------------------------
`default_nettype none

module fxc_out_stage
    import fxc_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          res_valid,
    input  wire fxc_result_t   res,
    output logic               res_ready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [23:0]        m_tdata,
    output logic [2:0]         m_tuser,
    output logic               m_tlast
);

    logic        valid_reg, valid_next;
    fxc_result_t res_reg;

    assign res_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (res_ready) begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.frame_length, res_reg.out_byte};
    assign m_tuser  = {res_reg.frame_ok, res_reg.item_kind};
    assign m_tlast  = res_reg.last;

endmodule

`default_nettype wire

FILE: design/fxc_checker.sv
// ---------------------------------------------------------------------------
// fxc_checker: port-level checks for the frame receiver
// Watches the result channel for consistent frame-end and data words.
// ---------------------------------------------------------------------------
`default_nettype none

module fxc_checker
    import fxc_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);

    // tlast marks exactly the frame-end words
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser[1:0] == KIND_END)))
        else $error("tlast does not match frame-end kind");

    // type and payload words carry no length and no ok flag
    a_data_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[23:8] == '0 && !m_tuser[2]))
        else $error("length or ok flag set on a data word");

    // frame-end word has a zero data byte
    a_end_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[7:0] == '0))
        else $error("nonzero byte on frame-end word");

    // a stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("result word changed while stalled");

endmodule

bind frame_receiver_xor_check fxc_checker u_fxc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
